>>> src/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg: shared types, constants and table builders
// Kind codes, configuration indexes, divider control types and the
// elaboration-time builders for the log2 and exp2 tables.
// ----------------------------------------------------------------------------
package trp_pkg;

  // transaction kinds
  localparam logic [3:0] KIND_SET_UI    = 4'd0;
  localparam logic [3:0] KIND_DEZIP_DEF = 4'd1;
  localparam logic [3:0] KIND_DEZIP_LEN = 4'd2;
  localparam logic [3:0] KIND_START     = 4'd3;
  localparam logic [3:0] KIND_SET_NOW   = 4'd4;
  localparam logic [3:0] KIND_GET_STEP  = 4'd5;
  localparam logic [3:0] KIND_GET       = 4'd6;
  localparam logic [3:0] KIND_STEP_BY   = 4'd7;
  localparam logic [3:0] KIND_CLEAR     = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_DEFAULT_LEN = 2'd0;
  localparam logic [1:0] CFG_TAPER       = 2'd1;
  localparam logic [1:0] CFG_SKEW        = 2'd2;

  localparam int DIVQ_W      = 29;
  localparam int EXP_W       = 31;
  localparam int LOG_W       = 17;
  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [15:0] SKEW_ONE = 16'h8000;
  localparam logic [4:0] ITERS_X = 5'd16;
  localparam logic [4:0] ITERS_E = 5'd29;

  typedef struct packed {
    logic       start;
    logic [4:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = v_in;
    res = '0;
    bitv = 64'h1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/N) in Q.16, by repeated squaring
  function automatic logic [LOG_W-1:0] log_entry(input int i, input int tbits);
    logic [63:0] m;
    logic [16:0] r;
    m = (64'h1 << 30) + (64'(i) << (30 - tbits));
    r = '0;
    if (i >= (1 << tbits)) return 17'h10000;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'h2 << 30)) begin
        m = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // 2^(-i/N) in Q1.30
  function automatic logic [EXP_W-1:0] exp_entry(input int i, input int tbits);
    logic [63:0] roots [13];
    logic [63:0] acc;
    logic [63:0] rem;
    logic [63:0] quo;
    for (int k = 0; k < 13; k++) roots[k] = '0;
    roots[0] = 64'h2 << 30;
    for (int k = 1; k <= tbits; k++) roots[k] = isqrt64(roots[k-1] << 30);
    acc = 64'h1 << 30;
    for (int b = 0; b <= tbits; b++) begin
      if (((i >> b) & 1) != 0) acc = (acc * roots[tbits - b]) >> 30;
    end
    rem = '0;
    quo = '0;
    for (int j = 60; j >= 0; j--) begin
      rem = (rem << 1) | ((j == 60) ? 64'h1 : 64'h0);
      if (rem >= acc) begin
        rem = rem - acc;
        quo[j] = 1'b1;
      end
    end
    return EXP_W'(quo);
  endfunction

endpackage

>>> src/trp_div.sv
// ----------------------------------------------------------------------------
// trp_div: shared restoring divider
// One quotient bit per cycle; the partial remainder may be preloaded.
// ----------------------------------------------------------------------------
module trp_div #(
  parameter int DW = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  trp_pkg::div_ctl_t          ctl,
  input  logic [DW-1:0]              init_rem,
  input  logic [trp_pkg::DIVQ_W-1:0] dividend,
  input  logic [DW-1:0]              divisor,
  output trp_pkg::div_sts_t          sts,
  output logic [trp_pkg::DIVQ_W-1:0] quotient
);

  logic [DW-1:0]              rem_r;
  logic [trp_pkg::DIVQ_W-1:0] dvd_r;
  logic [trp_pkg::DIVQ_W-1:0] quo_r;
  logic [DW-1:0]              dsr_r;
  logic [4:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [DW:0]                rem_sh;
  logic                       ge;
  logic [DW-1:0]              rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[trp_pkg::DIVQ_W-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? DW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        rem_r  <= init_rem;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        quo_r  <= '0;
        cnt_r  <= ctl.iters;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[trp_pkg::DIVQ_W-2:0], 1'b0};
        quo_r <= {quo_r[trp_pkg::DIVQ_W-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

>>> src/tapered_parameter_ramp_top.sv
// ----------------------------------------------------------------------------
// tapered_parameter_ramp_top: dezipper ramp for one audio parameter
// Tapered, skewed ramp from a start value to a goal, driven by commands.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one output transaction carrying the
// parameter value (signed Q16.16) and the ramping flag as they stood before
// the command took effect. A transaction with no ramp running goes straight
// from idle to completion; during a ramp it also uses the shared
// restoring divider (16 steps for the ramp position, 29 steps for the
// inverse-taper exponent) plus multiplier passes for the table
// interpolation and the blend. The input side is not ready while a
// transaction is in work; a finished result waits in the output register
// so that the next command can be taken meanwhile. Configuration writes
// are meant for idle periods.
module tapered_parameter_ramp_top #(
  parameter int COUNT_BITS     = 24,
  parameter int POW_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: value[31:0], count[55:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // in_tuser: kind[3:0]
  input  logic [3:0]  in_tuser,
  // out_tdata: param_value[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: ramping[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int CB     = COUNT_BITS;
  localparam int TB     = POW_TABLE_BITS;
  localparam int TBL_N  = 1 << TB;
  localparam int LREM_W = 32 - TB;
  localparam int EREM_W = 16 - TB;
  localparam int DW     = (CB > 12) ? CB : 12;
  localparam int QW     = trp_pkg::DIVQ_W;
  localparam int EW     = trp_pkg::EXP_W;
  localparam int LW     = trp_pkg::LOG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, PW_NORM, PW_LOG, PW_INTERP, PW_EMUL, PW_EDIV, PW_EXP,
    PW_SHIFT, PW_RET, S_W1, S_W2, S_W3, S_D1, S_D2, S_DONE
  } state_t;

  // constant log2 / exp2 tables
  logic [LW-1:0] log_rom [TBL_N+1];
  logic [EW-1:0] exp_rom [TBL_N+1];

  for (genvar gi = 0; gi <= TBL_N; gi++) begin : g_tab
    localparam logic [LW-1:0] LV = trp_pkg::log_entry(gi, TB);
    localparam logic [EW-1:0] EV = trp_pkg::exp_entry(gi, TB);
    assign log_rom[gi] = LV;
    assign exp_rom[gi] = EV;
  end

  state_t state_r;

  // configuration
  logic [23:0] def_len_r;
  logic [11:0] taper_r;
  logic [15:0] skew_r;

  // architectural state
  logic signed [31:0] start_r, goal_r, ui_r;
  logic               pend_r;
  logic [CB-1:0]      rl_r, sl_r;

  // latched transaction
  logic [3:0]  kind_r;
  logic [31:0] val_r;
  logic [CB-1:0] cnt_r;
  logic        ramping_r;
  logic [31:0] cur_r;

  // datapath
  logic [15:0]   x_r;
  logic [16:0]   pq_r;
  logic          inv_r, which_r;
  logic [TB-1:0] idx_r;
  logic [LREM_W-1:0] lrem_r;
  logic [4:0]    kmag_r;
  logic [LW-1:0] lo_r;
  logic [QW-1:0] e_r;
  logic [EW-1:0] ex0_r;
  logic [4:0]    sh_r;
  logic [30:0]   pw_r, p1_r, p2_r, w_r;
  logic [63:0]   acc_r;
  logic [31:0]   dmag_r;
  logic          dneg_r;
  logic [31:0]   mul_a_r, mul_b_r;
  logic [63:0]   mul_p;

  // divider
  trp_pkg::div_ctl_t div_ctl_r;
  trp_pkg::div_sts_t div_sts;
  logic [DW-1:0] div_rem0_r, div_dsr_r;
  logic [QW-1:0] div_dvd_r, div_quo;
  logic          div_go;

  // output register
  logic        out_tvalid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;

  // combinational helpers
  logic [CB-1:0]  in_cnt, elapsed, def_len;
  logic [11:0]    taper_eff;
  logic [15:0]    skew_sat;
  logic [3:0]     msb_k;
  logic [31:0]    frac32;
  logic [TB:0]    lidx1, eidx0, eidx1;
  logic [20:0]    interp21, mag21;
  logic [EW-1:0]  ex_val;
  logic signed [32:0] dlt;
  logic [31:0]    rmag;
  logic           out_free;

  // next architectural state
  logic signed [31:0] start_nxt, goal_nxt, ui_nxt, ramp_v;
  logic               pend_nxt, ramp_go;
  logic [CB-1:0]      rl_nxt, sl_nxt, ramp_len;

  trp_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl_r),
    .init_rem (div_rem0_r),
    .dividend (div_dvd_r),
    .divisor  (div_dsr_r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  assign mul_p = 64'(mul_a_r) * 64'(mul_b_r);

  always_comb begin
    in_cnt    = CB'(in_tdata[55:32]);
    elapsed   = (sl_r >= rl_r) ? '0 : rl_r - sl_r;
    def_len   = CB'(def_len_r);
    taper_eff = (taper_r == 12'd0) ? 12'd1 : taper_r;
    skew_sat  = (skew_r > trp_pkg::SKEW_ONE) ? trp_pkg::SKEW_ONE : skew_r;
    msb_k = '0;
    for (int i = 0; i < 16; i++) begin
      if (pq_r[i]) msb_k = 4'(i);
    end
    // drop the leading one, left-align the fraction
    frac32   = 32'({pq_r[15:0], 16'h0} << (5'd16 - {1'b0, msb_k}));
    lidx1    = {1'b0, idx_r} + (TB+1)'(1);
    interp21 = 21'(lo_r) + 21'(mul_p >> LREM_W);
    mag21    = {kmag_r, 16'h0} - interp21;
    eidx0    = {1'b0, e_r[15 -: TB]};
    eidx1    = eidx0 + (TB+1)'(1);
    ex_val   = ex0_r - EW'(mul_p >> EREM_W);
    dlt      = 33'(goal_r) - 33'(start_r);
    rmag     = 32'((mul_p + (64'h1 << 29)) >> 30);
    out_free = !out_tvalid_r || out_tready;
    // launch the divider for the ramp position or the inverse-taper exponent
    div_go   = ((state_r == S_IDLE) && in_tvalid && (sl_r != '0) && (rl_r != '0)) ||
               ((state_r == PW_INTERP) && inv_r);
  end

  // command decode on the latched transaction
  always_comb begin
    start_nxt = start_r;
    goal_nxt  = goal_r;
    ui_nxt    = ui_r;
    pend_nxt  = pend_r;
    rl_nxt    = rl_r;
    sl_nxt    = sl_r;
    ramp_go   = 1'b0;
    ramp_v    = val_r;
    ramp_len  = cnt_r;
    unique case (kind_r)
      trp_pkg::KIND_SET_UI: begin
        ui_nxt   = val_r;
        pend_nxt = 1'b1;
      end
      trp_pkg::KIND_DEZIP_DEF, trp_pkg::KIND_DEZIP_LEN: begin
        if (pend_r) begin
          pend_nxt = 1'b0;
          ramp_go  = 1'b1;
          ramp_v   = ui_r;
          ramp_len = (kind_r == trp_pkg::KIND_DEZIP_DEF) ? def_len : cnt_r;
        end
      end
      trp_pkg::KIND_START: begin
        ramp_go = 1'b1;
      end
      trp_pkg::KIND_SET_NOW: begin
        ramp_go  = 1'b1;
        ramp_len = '0;
      end
      trp_pkg::KIND_GET_STEP: begin
        if (sl_r != '0) sl_nxt = sl_r - CB'(1);
      end
      trp_pkg::KIND_STEP_BY: begin
        sl_nxt = (cnt_r >= sl_r) ? '0 : sl_r - cnt_r;
      end
      trp_pkg::KIND_CLEAR: begin
        pend_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    if (ramp_go) begin
      goal_nxt = ramp_v;
      ui_nxt   = ramp_v;
      if (ramp_len == '0) begin
        // zero length: jump straight to the value
        start_nxt = ramp_v;
        sl_nxt    = '0;
      end else begin
        start_nxt = cur_r;
        rl_nxt    = ramp_len;
        sl_nxt    = ramp_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      def_len_r    <= 24'd960;
      taper_r      <= 12'd256;
      skew_r       <= '0;
      start_r      <= '0;
      goal_r       <= '0;
      ui_r         <= '0;
      pend_r       <= 1'b0;
      rl_r         <= CB'(1);
      sl_r         <= '0;
      out_tvalid_r <= 1'b0;
      div_ctl_r    <= '0;
    end else begin
      div_ctl_r.start <= div_go;
      if (cfg_wr_en) begin
        priority case (cfg_index)
          trp_pkg::CFG_DEFAULT_LEN: def_len_r <= cfg_wdata;
          trp_pkg::CFG_TAPER:       taper_r   <= cfg_wdata[11:0];
          trp_pkg::CFG_SKEW:        skew_r    <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      // raise on completion, drop once the result is taken
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r    <= in_tuser;
            val_r     <= in_tdata[31:0];
            cnt_r     <= in_cnt;
            ramping_r <= (sl_r != '0);
            if (sl_r == '0 || rl_r == '0) begin
              cur_r   <= goal_r;
              state_r <= S_DONE;
            end else begin
              // position x = elapsed / length in Q0.16
              div_rem0_r      <= DW'(elapsed);
              div_dvd_r       <= '0;
              div_dsr_r       <= DW'(rl_r);
              div_ctl_r.iters <= trp_pkg::ITERS_X;
              state_r         <= S_DIVX;
            end
          end
        end
        S_DIVX: begin
          if (div_sts.done) begin
            x_r     <= div_quo[15:0];
            pq_r    <= {1'b0, div_quo[15:0]};
            inv_r   <= 1'b0;
            which_r <= 1'b0;
            state_r <= PW_NORM;
          end
        end
        PW_NORM: begin
          if (pq_r == '0) begin
            pw_r    <= '0;
            state_r <= PW_RET;
          end else if (pq_r[16]) begin
            pw_r    <= trp_pkg::ONE30;
            state_r <= PW_RET;
          end else begin
            idx_r   <= frac32[31 -: TB];
            lrem_r  <= frac32[LREM_W-1:0];
            kmag_r  <= 5'd16 - {1'b0, msb_k};
            state_r <= PW_LOG;
          end
        end
        PW_LOG: begin
          lo_r    <= log_rom[idx_r];
          mul_a_r <= 32'(log_rom[lidx1] - log_rom[idx_r]);
          mul_b_r <= 32'(lrem_r);
          state_r <= PW_INTERP;
        end
        PW_INTERP: begin
          if (!inv_r) begin
            mul_a_r <= 32'(mag21);
            mul_b_r <= 32'(taper_eff);
            state_r <= PW_EMUL;
          end else begin
            // exponent = mag * 256 / taper
            div_rem0_r      <= '0;
            div_dvd_r       <= QW'({mag21, 8'h0});
            div_dsr_r       <= DW'(taper_eff);
            div_ctl_r.iters <= trp_pkg::ITERS_E;
            state_r         <= PW_EDIV;
          end
        end
        PW_EMUL: begin
          e_r     <= QW'(mul_p >> 8);
          state_r <= PW_EXP;
        end
        PW_EDIV: begin
          if (div_sts.done) begin
            e_r     <= div_quo;
            state_r <= PW_EXP;
          end
        end
        PW_EXP: begin
          if ((|e_r[QW-1:21]) || (e_r[20:16] == 5'd31)) begin
            // underflows Q1.30
            pw_r    <= '0;
            state_r <= PW_RET;
          end else begin
            ex0_r   <= exp_rom[eidx0];
            mul_a_r <= 32'(exp_rom[eidx0] - exp_rom[eidx1]);
            mul_b_r <= 32'(e_r[EREM_W-1:0]);
            sh_r    <= e_r[20:16];
            state_r <= PW_SHIFT;
          end
        end
        PW_SHIFT: begin
          pw_r    <= 31'(ex_val >> sh_r);
          state_r <= PW_RET;
        end
        PW_RET: begin
          if (!which_r) begin
            // rising taper done, run the falling one on 1 - x
            p1_r    <= pw_r;
            pq_r    <= 17'h10000 - {1'b0, x_r};
            inv_r   <= 1'b1;
            which_r <= 1'b1;
            state_r <= PW_NORM;
          end else begin
            p2_r    <= trp_pkg::ONE30 - pw_r;
            state_r <= S_W1;
          end
        end
        S_W1: begin
          mul_a_r <= 32'(p1_r);
          mul_b_r <= 32'(trp_pkg::SKEW_ONE - skew_sat);
          dneg_r  <= dlt[32];
          dmag_r  <= dlt[32] ? 32'(-dlt) : dlt[31:0];
          state_r <= S_W2;
        end
        S_W2: begin
          acc_r   <= mul_p;
          mul_a_r <= 32'(p2_r);
          mul_b_r <= 32'(skew_sat);
          state_r <= S_W3;
        end
        S_W3: begin
          w_r     <= 31'((acc_r + mul_p) >> 15);
          state_r <= S_D1;
        end
        S_D1: begin
          mul_a_r <= dmag_r;
          mul_b_r <= 32'(w_r);
          state_r <= S_D2;
        end
        S_D2: begin
          // round half away from zero on the magnitude
          cur_r   <= dneg_r ? start_r - rmag : start_r + rmag;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r   <= cur_r;
            out_user_r   <= ramping_r;
            start_r      <= start_nxt;
            goal_r       <= goal_nxt;
            ui_r         <= ui_nxt;
            pend_r       <= pend_nxt;
            rl_r         <= rl_nxt;
            sl_r         <= sl_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // the divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIVX || state_r == PW_EDIV))
    else $error("divider finished outside a wait state");

  // one transaction in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // a new result appears only when a transaction completes
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  // the remaining count never exceeds the ramp length
  a_left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    sl_r <= rl_r)
    else $error("samples left exceed ramp length");

endmodule
